// File: rtl/gpg_pkg.sv
// Shared types, constants and the font table of the glyph pixel generator.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing.
package gpg_pkg;

  // Font geometry.
  localparam int GLYPH_ROWS  = 5;
  localparam int GLYPH_COLS  = 3;
  localparam int GLYPH_COUNT = 37;
  localparam int GLYPH_DOTS  = GLYPH_ROWS * GLYPH_COLS;
  localparam int BLANK_GLYPH = 36;
  localparam int DIGIT_BASE  = 26;

  // Field widths.
  localparam int CODE_W   = 8;
  localparam int COORD_W  = 16;
  localparam int SCALE_W  = 7;
  localparam int COLOUR_W = 32;
  localparam int INDEX_W  = $clog2(GLYPH_COUNT);
  localparam int COL_W    = $clog2(GLYPH_COLS);

  // The pen moves four dots to the right after every character.
  localparam int PEN_SHIFT = 2;

  // Dot scale limits.
  localparam logic [SCALE_W-1:0] SCALE_MIN = SCALE_W'(1);
  localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(64);

  // Character code boundaries.
  localparam logic [CODE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CODE_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CODE_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CODE_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CODE_W-1:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [CODE_W-1:0] CHAR_DIGIT_9 = 8'h39;

  // Glyph bitmaps, top row in the upper three bits; within a row the leftmost
  // dot is the upper bit. Scan order dot k therefore sits at bit GLYPH_DOTS-1-k.
  localparam logic [GLYPH_DOTS-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
    {3'd7, 3'd5, 3'd7, 3'd5, 3'd5}, {3'd6, 3'd5, 3'd6, 3'd5, 3'd6},
    {3'd7, 3'd4, 3'd4, 3'd4, 3'd7}, {3'd6, 3'd5, 3'd5, 3'd5, 3'd6},
    {3'd7, 3'd4, 3'd7, 3'd4, 3'd7}, {3'd7, 3'd4, 3'd7, 3'd4, 3'd4},
    {3'd7, 3'd4, 3'd5, 3'd5, 3'd7}, {3'd5, 3'd5, 3'd7, 3'd5, 3'd5},
    {3'd7, 3'd2, 3'd2, 3'd2, 3'd7}, {3'd1, 3'd1, 3'd1, 3'd5, 3'd7},
    {3'd5, 3'd6, 3'd4, 3'd6, 3'd5}, {3'd4, 3'd4, 3'd4, 3'd4, 3'd7},
    {3'd5, 3'd7, 3'd7, 3'd5, 3'd5}, {3'd5, 3'd7, 3'd7, 3'd7, 3'd5},
    {3'd7, 3'd5, 3'd5, 3'd5, 3'd7}, {3'd7, 3'd5, 3'd7, 3'd4, 3'd4},
    {3'd7, 3'd5, 3'd5, 3'd7, 3'd3}, {3'd7, 3'd5, 3'd6, 3'd5, 3'd5},
    {3'd7, 3'd4, 3'd7, 3'd1, 3'd7}, {3'd7, 3'd2, 3'd2, 3'd2, 3'd2},
    {3'd5, 3'd5, 3'd5, 3'd5, 3'd7}, {3'd5, 3'd5, 3'd5, 3'd5, 3'd2},
    {3'd5, 3'd5, 3'd7, 3'd7, 3'd5}, {3'd5, 3'd5, 3'd2, 3'd5, 3'd5},
    {3'd5, 3'd5, 3'd2, 3'd2, 3'd2}, {3'd7, 3'd1, 3'd2, 3'd4, 3'd7},
    {3'd7, 3'd5, 3'd5, 3'd5, 3'd7}, {3'd2, 3'd6, 3'd2, 3'd2, 3'd7},
    {3'd7, 3'd1, 3'd7, 3'd4, 3'd7}, {3'd7, 3'd1, 3'd7, 3'd1, 3'd7},
    {3'd5, 3'd5, 3'd7, 3'd1, 3'd1}, {3'd7, 3'd4, 3'd7, 3'd1, 3'd7},
    {3'd7, 3'd4, 3'd7, 3'd5, 3'd7}, {3'd7, 3'd1, 3'd2, 3'd2, 3'd2},
    {3'd7, 3'd5, 3'd7, 3'd5, 3'd7}, {3'd7, 3'd5, 3'd7, 3'd1, 3'd7},
    {3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
  };

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } gpg_state_e;

  // One character transaction as seen by the datapath.
  typedef struct packed {
    logic [CODE_W-1:0]   char_code;
    logic                first_of_text;
    logic [COORD_W-1:0]  start_x;
    logic [COORD_W-1:0]  start_y;
    logic [SCALE_W-1:0]  scale_in;
    logic [COLOUR_W-1:0] colour_in;
  } gpg_char_t;

  // One pixel transaction as produced by the datapath.
  typedef struct packed {
    logic [COORD_W-1:0]  pixel_x;
    logic [COORD_W-1:0]  pixel_y;
    logic [SCALE_W-1:0]  pixel_size;
    logic [COLOUR_W-1:0] pixel_colour;
    logic                last_pixel;
  } gpg_pixel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // take the character transaction on the input channel
    logic step;  // scan one glyph dot
  } gpg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic glyph_lit;  // the presented character has at least one lit dot
    logic slot_free;  // the output register can take a pixel this cycle
    logic scan_done;  // no lit dot remains after the current one
  } gpg_status_t;

  // Maps a character code onto its glyph: letters ignore case, digits follow.
  function automatic logic [INDEX_W-1:0] glyph_index(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] offs;
    offs = CODE_W'(BLANK_GLYPH);
    if (code inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
      offs = code - CHAR_UPPER_A;
    end else if (code inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
      offs = code - CHAR_LOWER_A;
    end else if (code inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
      offs = code - CHAR_DIGIT_0 + CODE_W'(DIGIT_BASE);
    end
    return offs[INDEX_W-1:0];
  endfunction

endpackage

// File: rtl/gpg_char_if.sv
// Input channel of the glyph pixel generator: valid/ready and one character.
// Depends on gpg_pkg for the field widths.
interface gpg_char_if;
  logic                                valid;
  logic                                ready;
  logic [gpg_pkg::CODE_W-1:0]          char_code;
  logic                                first_of_text;
  logic signed [gpg_pkg::COORD_W-1:0]  start_x;
  logic signed [gpg_pkg::COORD_W-1:0]  start_y;
  logic [gpg_pkg::SCALE_W-1:0]         scale_in;
  logic [gpg_pkg::COLOUR_W-1:0]        colour_in;

  modport source (
    output valid, char_code, first_of_text, start_x, start_y, scale_in, colour_in,
    input  ready
  );

  modport sink (
    input  valid, char_code, first_of_text, start_x, start_y, scale_in, colour_in,
    output ready
  );
endinterface

// File: rtl/gpg_pixel_if.sv
// Output channel of the glyph pixel generator: valid/ready and one pixel.
// Depends on gpg_pkg for the field widths.
interface gpg_pixel_if;
  logic                                valid;
  logic                                ready;
  logic signed [gpg_pkg::COORD_W-1:0]  pixel_x;
  logic signed [gpg_pkg::COORD_W-1:0]  pixel_y;
  logic [gpg_pkg::SCALE_W-1:0]         pixel_size;
  logic [gpg_pkg::COLOUR_W-1:0]        pixel_colour;
  logic                                last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_size, pixel_colour, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_size, pixel_colour, last_pixel,
    output ready
  );
endinterface

// File: rtl/gpg_ctrl.sv
// Controller of the glyph pixel generator: sequences load and dot scan.
// Depends on gpg_pkg for the state enum and the command and status structs.
module gpg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  gpg_pkg::gpg_status_t status_i,
  output gpg_pkg::gpg_cmd_t    cmd_o
);

  gpg_pkg::gpg_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gpg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: a lit glyph is scanned, a blank one only moves the pen.
  always_comb begin
    state_d = state_q;
    case (state_q)
      gpg_pkg::ST_IDLE: begin
        if (in_valid_i && status_i.glyph_lit) begin
          state_d = gpg_pkg::ST_SCAN;
        end
      end
      gpg_pkg::ST_SCAN: begin
        if (status_i.slot_free && status_i.scan_done) begin
          state_d = gpg_pkg::ST_IDLE;
        end
      end
      default: state_d = gpg_pkg::ST_IDLE;
    endcase
  end

  // Outputs: accept characters while idle, scan while the output slot is free.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      gpg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      gpg_pkg::ST_SCAN: begin
        cmd_o.step = status_i.slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/gpg_datapath.sv
// Datapath of the glyph pixel generator: string state, pen, dot scan and the
// output register. Depends on gpg_pkg for widths, the font table and structs.
module gpg_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gpg_pkg::gpg_cmd_t    cmd_i,
  output gpg_pkg::gpg_status_t status_o,
  input  gpg_pkg::gpg_char_t   char_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output gpg_pkg::gpg_pixel_t  pixel_o
);

  localparam int DOTS    = gpg_pkg::GLYPH_DOTS;
  localparam int COORD_W = gpg_pkg::COORD_W;
  localparam int SCALE_W = gpg_pkg::SCALE_W;

  // String state.
  logic [COORD_W-1:0]          pen_x_q, pen_x_d;
  logic [COORD_W-1:0]          text_top_q, text_top_d;
  logic [SCALE_W-1:0]          scale_q, scale_d;
  logic [gpg_pkg::COLOUR_W-1:0] colour_q, colour_d;

  // Scan state of the current character.
  logic [COORD_W-1:0]          char_x_q, char_x_d;
  logic [COORD_W-1:0]          dot_x_q, dot_x_d;
  logic [COORD_W-1:0]          dot_y_q, dot_y_d;
  logic [gpg_pkg::COL_W-1:0]   col_q, col_d;
  logic [DOTS-1:0]             rem_q, rem_d;

  // Output register.
  logic                        out_valid_q, out_valid_d;
  gpg_pkg::gpg_pixel_t         pixel_q, pixel_d;

  // Decode of the presented character.
  logic [DOTS-1:0]             rom_bits;
  logic [DOTS-1:0]             scan_bits;
  logic [SCALE_W-1:0]          scale_sat;
  logic [COORD_W-1:0]          base_x;
  logic [SCALE_W-1:0]          scale_new;
  logic [COORD_W-1:0]          scale_ext;
  logic                        emit;

  // Glyph lookup, put into scan order with the first dot in bit zero.
  always_comb begin
    rom_bits = gpg_pkg::GLYPH_ROM[gpg_pkg::glyph_index(char_i.char_code)];
    for (int k = 0; k < DOTS; k++) begin
      scan_bits[k] = rom_bits[DOTS-1-k];
    end
  end

  // Scale is clamped to its legal range when a string starts.
  always_comb begin
    if (char_i.scale_in < gpg_pkg::SCALE_MIN) begin
      scale_sat = gpg_pkg::SCALE_MIN;
    end else if (char_i.scale_in > gpg_pkg::SCALE_MAX) begin
      scale_sat = gpg_pkg::SCALE_MAX;
    end else begin
      scale_sat = char_i.scale_in;
    end
  end

  assign base_x    = char_i.first_of_text ? char_i.start_x : pen_x_q;
  assign scale_new = char_i.first_of_text ? scale_sat : scale_q;
  assign scale_ext = COORD_W'(scale_q);
  assign emit      = cmd_i.step && rem_q[0];

  // Status towards the controller.
  assign status_o.glyph_lit = |scan_bits;
  assign status_o.slot_free = !out_valid_q || out_ready_i;
  assign status_o.scan_done = (rem_q[DOTS-1:1] == '0);

  // Latch the string on its first character and advance the pen per character.
  always_comb begin
    pen_x_d    = pen_x_q;
    text_top_d = text_top_q;
    scale_d    = scale_q;
    colour_d   = colour_q;
    if (cmd_i.load) begin
      pen_x_d = base_x + COORD_W'({scale_new, {gpg_pkg::PEN_SHIFT{1'b0}}});
      scale_d = scale_new;
      if (char_i.first_of_text) begin
        text_top_d = char_i.start_y;
        colour_d   = char_i.colour_in;
      end
    end
  end

  // Dot scan: x and y step by the scale, x returns to the left edge per row.
  always_comb begin
    char_x_d = char_x_q;
    dot_x_d  = dot_x_q;
    dot_y_d  = dot_y_q;
    col_d    = col_q;
    rem_d    = rem_q;
    if (cmd_i.load) begin
      char_x_d = base_x;
      dot_x_d  = base_x;
      dot_y_d  = char_i.first_of_text ? char_i.start_y : text_top_q;
      col_d    = '0;
      rem_d    = scan_bits;
    end else if (cmd_i.step) begin
      rem_d = rem_q >> 1;
      if (col_q == gpg_pkg::COL_W'(gpg_pkg::GLYPH_COLS - 1)) begin
        col_d   = '0;
        dot_x_d = char_x_q;
        dot_y_d = dot_y_q + scale_ext;
      end else begin
        col_d   = col_q + gpg_pkg::COL_W'(1);
        dot_x_d = dot_x_q + scale_ext;
      end
    end
  end

  // Output register: filled by a lit dot, emptied when the sink takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    pixel_d     = pixel_q;
    if (emit) begin
      out_valid_d          = 1'b1;
      pixel_d.pixel_x      = dot_x_q;
      pixel_d.pixel_y      = dot_y_q;
      pixel_d.pixel_size   = scale_q;
      pixel_d.pixel_colour = colour_q;
      pixel_d.last_pixel   = status_o.scan_done;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and string state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q     <= '0;
      text_top_q  <= '0;
      scale_q     <= gpg_pkg::SCALE_MIN;
      colour_q    <= '0;
      rem_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pen_x_q     <= pen_x_d;
      text_top_q  <= text_top_d;
      scale_q     <= scale_d;
      colour_q    <= colour_d;
      rem_q       <= rem_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    char_x_q <= char_x_d;
    dot_x_q  <= dot_x_d;
    dot_y_q  <= dot_y_d;
    pixel_q  <= pixel_d;
  end

  assign out_valid_o = out_valid_q;
  assign pixel_o     = pixel_q;

endmodule

// File: rtl/glyph_pixel_generator_core.sv
// The glyph pixel generator takes one character transaction, loads it and
// then scans its 3x5 glyph at one dot per cycle while the output slot is
// free, emitting one pixel transaction per lit dot; the scan stops at the
// last lit dot, and a blank character is only loaded and not scanned. The
// dot scan in the datapath pauses while the output register holds a pixel
// that the sink has not taken. The next character is accepted in the cycle
// after the last lit dot has been scanned.
// Top level of the glyph pixel generator: joins the channel interfaces, the
// controller and the datapath. Depends on gpg_pkg, gpg_char_if, gpg_pixel_if,
// gpg_ctrl and gpg_datapath.
module glyph_pixel_generator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  gpg_char_if.sink    char_i,
  gpg_pixel_if.source pixel_o
);

  gpg_pkg::gpg_cmd_t    cmd;
  gpg_pkg::gpg_status_t status;
  gpg_pkg::gpg_char_t   char_data;
  gpg_pkg::gpg_pixel_t  pixel_data;
  logic                 in_ready;
  logic                 out_valid;

  // Gather the input fields into one bundle.
  assign char_data.char_code     = char_i.char_code;
  assign char_data.first_of_text = char_i.first_of_text;
  assign char_data.start_x       = char_i.start_x;
  assign char_data.start_y       = char_i.start_y;
  assign char_data.scale_in      = char_i.scale_in;
  assign char_data.colour_in     = char_i.colour_in;
  assign char_i.ready            = in_ready;

  gpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (char_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gpg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .char_i      (char_data),
    .out_valid_o (out_valid),
    .out_ready_i (pixel_o.ready),
    .pixel_o     (pixel_data)
  );

  // Spread the pixel bundle onto the output channel.
  assign pixel_o.valid        = out_valid;
  assign pixel_o.pixel_x      = pixel_data.pixel_x;
  assign pixel_o.pixel_y      = pixel_data.pixel_y;
  assign pixel_o.pixel_size   = pixel_data.pixel_size;
  assign pixel_o.pixel_colour = pixel_data.pixel_colour;
  assign pixel_o.last_pixel   = pixel_data.last_pixel;

endmodule
